FILE: rtl/sma_pkg.sv
// sma_pkg: shared types, field widths and codes of the size-matched storage allocator
// used by sma_csr, sma_cell and size_matched_storage_allocator
package sma_pkg;

   localparam int DEV_W      = 4;
   localparam int COLOR_W    = 4;
   localparam int COUNT_W    = 32;
   localparam int BYTES_W    = 34;
   localparam int SHIFT_W    = 3;
   localparam int HI_W       = BYTES_W + (2 ** SHIFT_W) - 1;
   localparam int STAMP_W    = 32;
   localparam int ID_W       = 6;
   localparam int STATUS_W   = 3;
   localparam int TOTAL_W    = 48;
   localparam int ADDR_W     = 4;
   localparam int DATA_W     = 32;

   localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

   localparam int DEF_ENTRY_COUNT  = 64;
   localparam int DEF_DEVICE_COUNT = 16;
   localparam int DEF_COLOR_COUNT  = 16;

   // register indexes
   localparam logic [1:0] REG_REUSE_EN = 2'd0;
   localparam logic [1:0] REG_SHIFT    = 2'd1;
   localparam logic [1:0] REG_COLOR_EN = 2'd2;

   localparam logic               RST_REUSE_EN = 1'b1;
   localparam logic [SHIFT_W-1:0] RST_SHIFT    = 3'd4;
   localparam logic               RST_COLOR_EN = 1'b0;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_REUSED   = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NEW      = 3'd1;
   localparam logic [STATUS_W-1:0] ST_SCALAR   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_EXTERNAL = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;
   localparam logic [STATUS_W-1:0] ST_BAD_REL  = 3'd5;

   // entry update kinds
   localparam logic [1:0] CMD_NONE    = 2'd0;
   localparam logic [1:0] CMD_NEW     = 2'd1;
   localparam logic [1:0] CMD_REUSE   = 2'd2;
   localparam logic [1:0] CMD_RELEASE = 2'd3;

   typedef struct packed {
      logic [BYTES_W-1:0] size;
      logic [HI_W-1:0]    hi;
      logic [BYTES_W-1:0] lo;
      logic [DEV_W-1:0]   dev;
      logic [COLOR_W-1:0] color;
      logic               color_en;
      logic [STAMP_W-1:0] stamp;
   } sma_query_type;

   typedef struct packed {
      logic               up_valid;
      logic [BYTES_W-1:0] up_bytes;
      logic [STAMP_W-1:0] up_age;
      logic               dn_valid;
      logic [BYTES_W-1:0] dn_bytes;
      logic [STAMP_W-1:0] dn_age;
   } sma_token_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic [DEV_W-1:0]   dev;
      logic [BYTES_W-1:0] bytes;
      logic [COLOR_W-1:0] color;
      logic [STAMP_W-1:0] stamp;
   } sma_cmd_type;

endpackage

FILE: rtl/sma_csr.sv
// sma_csr: configuration registers behind the apb-style port
// depends on sma_pkg
module sma_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [sma_pkg::ADDR_W-1:0]   paddr,
   input  logic [sma_pkg::DATA_W-1:0]   pwdata,
   output logic [sma_pkg::DATA_W-1:0]   prdata,
   output logic                         pready,
   output logic                         reuse_en,
   output logic [sma_pkg::SHIFT_W-1:0]  match_shift,
   output logic                         color_en
);

   logic                        reuse_en_ff, reuse_en_in;
   logic [sma_pkg::SHIFT_W-1:0] shift_ff, shift_in;
   logic                        color_en_ff, color_en_in;
   logic                        wr;
   logic [1:0]                  reg_idx;

   assign pready  = 1'b1;
   assign wr      = psel && penable && pwrite;
   assign reg_idx = paddr[3:2];

   always_comb begin
      reuse_en_in = reuse_en_ff;
      shift_in    = shift_ff;
      color_en_in = color_en_ff;
      if (wr) begin
         unique case (reg_idx)
            sma_pkg::REG_REUSE_EN: reuse_en_in = pwdata[0];
            sma_pkg::REG_SHIFT:    shift_in    = pwdata[sma_pkg::SHIFT_W-1:0];
            sma_pkg::REG_COLOR_EN: color_en_in = pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         sma_pkg::REG_REUSE_EN: prdata = sma_pkg::DATA_W'(reuse_en_ff);
         sma_pkg::REG_SHIFT:    prdata = sma_pkg::DATA_W'(shift_ff);
         sma_pkg::REG_COLOR_EN: prdata = sma_pkg::DATA_W'(color_en_ff);
         default:               prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reuse_en_ff <= sma_pkg::RST_REUSE_EN;
         shift_ff    <= sma_pkg::RST_SHIFT;
         color_en_ff <= sma_pkg::RST_COLOR_EN;
      end else begin
         reuse_en_ff <= reuse_en_in;
         shift_ff    <= shift_in;
         color_en_ff <= color_en_in;
      end
   end

   assign reuse_en    = reuse_en_ff;
   assign match_shift = shift_ff;
   assign color_en    = color_en_ff;

endmodule

FILE: rtl/sma_cell.sv
// sma_cell: one table entry plus one stage of the best-match search chain
// depends on sma_pkg
module sma_cell #(
   parameter int IDX_W    = 6,
   parameter int CELL_IDX = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  sma_pkg::sma_query_type query,
   input  sma_pkg::sma_cmd_type  cmd,
   input  logic [IDX_W-1:0]      cmd_idx,
   input  sma_pkg::sma_token_type tok_in,
   input  logic [IDX_W-1:0]      up_idx_in,
   input  logic [IDX_W-1:0]      dn_idx_in,
   output sma_pkg::sma_token_type tok_out,
   output logic [IDX_W-1:0]      up_idx_out,
   output logic [IDX_W-1:0]      dn_idx_out,
   output logic                  used,
   output logic                  free
);

   logic                          used_ff, used_in;
   logic                          free_ff, free_in;
   logic [sma_pkg::DEV_W-1:0]     dev_ff, dev_in;
   logic [sma_pkg::BYTES_W-1:0]   bytes_ff, bytes_in;
   logic [sma_pkg::COLOR_W-1:0]   color_ff, color_in;
   logic [sma_pkg::STAMP_W-1:0]   stamp_ff, stamp_in;
   sma_pkg::sma_token_type        tok_ff, tok_in_next;
   logic [IDX_W-1:0]              up_idx_ff, up_idx_in_next;
   logic [IDX_W-1:0]              dn_idx_ff, dn_idx_in_next;
   logic                          hit;
   logic                          elig;
   logic [sma_pkg::STAMP_W-1:0]   age;
   logic                          take_up, take_dn;

   assign hit = (cmd_idx == IDX_W'(CELL_IDX));

   always_comb begin
      used_in  = used_ff;
      free_in  = free_ff;
      dev_in   = dev_ff;
      bytes_in = bytes_ff;
      color_in = color_ff;
      stamp_in = stamp_ff;
      if (hit) begin
         unique case (cmd.kind)
            sma_pkg::CMD_NEW: begin
               used_in  = 1'b1;
               free_in  = 1'b0;
               dev_in   = cmd.dev;
               bytes_in = cmd.bytes;
            end
            sma_pkg::CMD_REUSE: begin
               free_in  = 1'b0;
               bytes_in = cmd.bytes;
            end
            sma_pkg::CMD_RELEASE: begin
               free_in  = 1'b1;
               color_in = cmd.color;
               stamp_in = cmd.stamp;
            end
            default: ;
         endcase
      end
   end

   // candidate compare against the best record handed in from the left
   always_comb begin
      elig = used_ff && free_ff && (dev_ff == query.dev) &&
             (!query.color_en || (color_ff == query.color));
      age  = query.stamp - stamp_ff;
      take_up = elig && (bytes_ff >= query.size) &&
                (sma_pkg::HI_W'(bytes_ff) <= query.hi) &&
                (!tok_in.up_valid || (bytes_ff < tok_in.up_bytes) ||
                 ((bytes_ff == tok_in.up_bytes) && (age > tok_in.up_age)));
      take_dn = elig && (bytes_ff >= query.lo) && (bytes_ff < query.size) &&
                (!tok_in.dn_valid || (bytes_ff > tok_in.dn_bytes) ||
                 ((bytes_ff == tok_in.dn_bytes) && (age < tok_in.dn_age)));
      tok_in_next    = tok_in;
      up_idx_in_next = up_idx_in;
      dn_idx_in_next = dn_idx_in;
      if (take_up) begin
         tok_in_next.up_valid = 1'b1;
         tok_in_next.up_bytes = bytes_ff;
         tok_in_next.up_age   = age;
         up_idx_in_next       = IDX_W'(CELL_IDX);
      end
      if (take_dn) begin
         tok_in_next.dn_valid = 1'b1;
         tok_in_next.dn_bytes = bytes_ff;
         tok_in_next.dn_age   = age;
         dn_idx_in_next       = IDX_W'(CELL_IDX);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= 1'b0;
         free_ff <= 1'b0;
      end else begin
         used_ff <= used_in;
         free_ff <= free_in;
      end
   end

   always_ff @(posedge clock) begin
      dev_ff    <= dev_in;
      bytes_ff  <= bytes_in;
      color_ff  <= color_in;
      stamp_ff  <= stamp_in;
      tok_ff    <= tok_in_next;
      up_idx_ff <= up_idx_in_next;
      dn_idx_ff <= dn_idx_in_next;
   end

   assign tok_out    = tok_ff;
   assign up_idx_out = up_idx_ff;
   assign dn_idx_out = dn_idx_ff;
   assign used       = used_ff;
   assign free       = free_ff;

endmodule

FILE: rtl/size_matched_storage_allocator.sv
// size_matched_storage_allocator: top level, chain of entry cells plus request sequencer
// depends on sma_pkg, sma_csr, sma_cell
//
//   channel  | direction | handshake             | payload
//   req      | in        | req_valid / req_stall | mode, device, element_count, ...
//   rsp      | out       | rsp_valid / rsp_stall | grant_id, status, total_bytes
//   csr      | in/out    | psel, penable, pready | paddr, pwdata, prdata
//
// a searching request passes the best-match record along the cell chain one cell per
// cycle in the scan state, then the commit state commits and loads the result;
// releases, scalar requests and requests with reuse off skip the scan state
// reset is synchronous and clears the entry flags, counters and byte total
// a result held by rsp_stall keeps the next item waiting in its commit cycle
module size_matched_storage_allocator #(
   parameter int ENTRY_COUNT  = sma_pkg::DEF_ENTRY_COUNT,
   parameter int DEVICE_COUNT = sma_pkg::DEF_DEVICE_COUNT,
   parameter int COLOR_COUNT  = sma_pkg::DEF_COLOR_COUNT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_mode,
   input  logic [sma_pkg::DEV_W-1:0]     req_device,
   input  logic [sma_pkg::COUNT_W-1:0]   req_element_count,
   input  logic                          req_is_scalar_shape,
   input  logic [sma_pkg::COLOR_W-1:0]   req_node_color,
   input  logic [sma_pkg::ID_W-1:0]      req_release_id,
   input  logic                          req_is_external,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [sma_pkg::ID_W-1:0]      rsp_grant_id,
   output logic [sma_pkg::STATUS_W-1:0]  rsp_status,
   output logic [sma_pkg::TOTAL_W-1:0]   rsp_total_bytes,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [sma_pkg::ADDR_W-1:0]    paddr,
   input  logic [sma_pkg::DATA_W-1:0]    pwdata,
   output logic [sma_pkg::DATA_W-1:0]    prdata,
   output logic                          pready
);

   localparam int IDX_W = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
   localparam int CNT_W = $clog2(ENTRY_COUNT + 1);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_FIN  = 2'd2;

   logic                          reuse_en;
   logic [sma_pkg::SHIFT_W-1:0]   match_shift;
   logic                          color_en;

   logic [1:0]                    state_ff, state_in;
   logic [IDX_W-1:0]              scan_ff, scan_in;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic [sma_pkg::STAMP_W-1:0]   stamp_ff, stamp_in;
   logic [sma_pkg::TOTAL_W-1:0]   total_ff, total_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [sma_pkg::ID_W-1:0]      rsp_id_ff, rsp_id_in;
   logic [sma_pkg::STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [sma_pkg::TOTAL_W-1:0]   rsp_total_ff;

   sma_pkg::sma_query_type        query_ff, query_in;
   logic                          mode_ff, scalar_ff, ext_ff;
   logic [sma_pkg::ID_W-1:0]      rid_ff;

   sma_pkg::sma_cmd_type          cmd;
   logic [IDX_W-1:0]              cmd_idx;

   sma_pkg::sma_token_type        tok_chain [0:ENTRY_COUNT];
   logic [IDX_W-1:0]              up_chain  [0:ENTRY_COUNT];
   logic [IDX_W-1:0]              dn_chain  [0:ENTRY_COUNT];
   logic [ENTRY_COUNT-1:0]        used_vec, free_vec;

   logic                          accept;
   logic                          out_free;
   logic [sma_pkg::DEV_W-1:0]     dev_sat;
   logic [sma_pkg::COLOR_W-1:0]   color_sat;
   logic [sma_pkg::BYTES_W-1:0]   size_new;
   logic [IDX_W-1:0]              rid_idx;
   logic [sma_pkg::BYTES_W-1:0]   hit_bytes;
   logic [IDX_W-1:0]              hit_idx;
   logic                          hit_any;
   logic [sma_pkg::BYTES_W-1:0]   delta;
   logic [sma_pkg::TOTAL_W:0]     sum;

   sma_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready),
      .reuse_en    (reuse_en),
      .match_shift (match_shift),
      .color_en    (color_en)
   );

   assign tok_chain[0] = '0;
   assign up_chain[0]  = '0;
   assign dn_chain[0]  = '0;

   for (genvar i = 0; i < ENTRY_COUNT; i++) begin : g_cell
      sma_cell #(
         .IDX_W    (IDX_W),
         .CELL_IDX (i)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .query      (query_ff),
         .cmd        (cmd),
         .cmd_idx    (cmd_idx),
         .tok_in     (tok_chain[i]),
         .up_idx_in  (up_chain[i]),
         .dn_idx_in  (dn_chain[i]),
         .tok_out    (tok_chain[i+1]),
         .up_idx_out (up_chain[i+1]),
         .dn_idx_out (dn_chain[i+1]),
         .used       (used_vec[i]),
         .free       (free_vec[i])
      );
   end

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // request decode into the broadcast query
   always_comb begin
      dev_sat   = (int'(req_device) >= DEVICE_COUNT) ?
                  sma_pkg::DEV_W'(DEVICE_COUNT - 1) : req_device;
      color_sat = (int'(req_node_color) >= COLOR_COUNT) ?
                  sma_pkg::COLOR_W'(COLOR_COUNT - 1) : req_node_color;
      size_new  = {req_element_count, 2'b00};
      query_in  = query_ff;
      if (accept) begin
         query_in.size     = size_new;
         query_in.hi       = sma_pkg::HI_W'(size_new) << match_shift;
         query_in.lo       = size_new >> match_shift;
         query_in.dev      = dev_sat;
         query_in.color    = color_sat;
         query_in.color_en = color_en;
         query_in.stamp    = stamp_ff;
      end
   end

   always_comb begin
      rid_idx = IDX_W'(rid_ff);
      hit_any = reuse_en && (tok_chain[ENTRY_COUNT].up_valid ||
                             tok_chain[ENTRY_COUNT].dn_valid);
      if (tok_chain[ENTRY_COUNT].up_valid) begin
         hit_bytes = tok_chain[ENTRY_COUNT].up_bytes;
         hit_idx   = up_chain[ENTRY_COUNT];
      end else begin
         hit_bytes = tok_chain[ENTRY_COUNT].dn_bytes;
         hit_idx   = dn_chain[ENTRY_COUNT];
      end
   end

   always_comb begin
      state_in      = state_ff;
      scan_in       = scan_ff;
      count_in      = count_ff;
      stamp_in      = stamp_ff;
      total_in      = total_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_id_in     = rsp_id_ff;
      rsp_status_in = rsp_status_ff;
      cmd           = '0;
      cmd.kind      = sma_pkg::CMD_NONE;
      cmd_idx       = '0;
      delta         = '0;
      sum           = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               scan_in = '0;
               if (!req_mode && !req_is_scalar_shape && reuse_en) begin
                  state_in = S_SCAN;
               end else begin
                  state_in = S_FIN;
               end
            end
         end
         S_SCAN: begin
            scan_in = scan_ff + 1'b1;
            if (scan_ff == IDX_W'(ENTRY_COUNT - 1)) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (out_free) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               rsp_id_in    = '0;
               if (mode_ff) begin
                  if (ext_ff) begin
                     rsp_status_in = sma_pkg::ST_EXTERNAL;
                  end else if (!(32'(rid_ff) < 32'(count_ff)) ||
                               !used_vec[rid_idx] || free_vec[rid_idx]) begin
                     rsp_status_in = sma_pkg::ST_BAD_REL;
                  end else begin
                     cmd.kind      = sma_pkg::CMD_RELEASE;
                     cmd.color     = query_ff.color;
                     cmd.stamp     = stamp_ff;
                     cmd_idx       = rid_idx;
                     stamp_in      = stamp_ff + 1'b1;
                     rsp_status_in = sma_pkg::ST_REUSED;
                  end
               end else if (scalar_ff) begin
                  rsp_status_in = sma_pkg::ST_SCALAR;
               end else if (hit_any) begin
                  cmd.kind  = sma_pkg::CMD_REUSE;
                  cmd_idx   = hit_idx;
                  if (query_ff.size > hit_bytes) begin
                     cmd.bytes = query_ff.size;
                     delta     = query_ff.size - hit_bytes;
                  end else begin
                     cmd.bytes = hit_bytes;
                  end
                  rsp_id_in     = sma_pkg::ID_W'(hit_idx);
                  rsp_status_in = sma_pkg::ST_REUSED;
               end else if (count_ff == CNT_W'(ENTRY_COUNT)) begin
                  rsp_status_in = sma_pkg::ST_FULL;
               end else begin
                  cmd.kind      = sma_pkg::CMD_NEW;
                  cmd.dev       = query_ff.dev;
                  cmd.bytes     = query_ff.size;
                  cmd_idx       = IDX_W'(count_ff);
                  count_in      = count_ff + 1'b1;
                  delta         = query_ff.size;
                  rsp_id_in     = sma_pkg::ID_W'(count_ff);
                  rsp_status_in = sma_pkg::ST_NEW;
               end
               // saturating running total
               sum = (sma_pkg::TOTAL_W+1)'(total_ff) + (sma_pkg::TOTAL_W+1)'(delta);
               if (sum > (sma_pkg::TOTAL_W+1)'(sma_pkg::TOTAL_MAX)) begin
                  total_in = sma_pkg::TOTAL_MAX;
               end else begin
                  total_in = sum[sma_pkg::TOTAL_W-1:0];
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         scan_ff      <= '0;
         count_ff     <= '0;
         stamp_ff     <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_ff      <= scan_in;
         count_ff     <= count_in;
         stamp_ff     <= stamp_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      query_ff      <= query_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_status_ff <= rsp_status_in;
      if (state_ff == S_FIN && out_free) begin
         rsp_total_ff <= total_in;
      end
      if (accept) begin
         mode_ff   <= req_mode;
         scalar_ff <= req_is_scalar_shape;
         ext_ff    <= req_is_external;
         rid_ff    <= req_release_id;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_grant_id    = rsp_id_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_total_bytes = rsp_total_ff;

endmodule
